// ===== design/chacha20_stream_xor_unit_defines.svh =====
// Assertion macros for the ChaCha20 stream XOR unit.
// Used by the RTL files that carry concurrent assertions.
`ifndef CHACHA20_STREAM_XOR_UNIT_DEFINES_SVH
`define CHACHA20_STREAM_XOR_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CSX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CSX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/csx_pkg.sv =====
// Package for the ChaCha20 stream XOR unit: constants, types, quarter-round.
// No dependencies.
`default_nettype none
package csx_pkg;
    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int QDEPTH = 2;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef enum logic [2:0] {
        REG_KEY01   = 3'd0,
        REG_KEY23   = 3'd1,
        REG_KEY45   = 3'd2,
        REG_KEY67   = 3'd3,
        REG_NONCE01 = 3'd4,
        REG_NONCE2  = 3'd5,
        REG_START   = 3'd6
    } t_reg_idx;

    // Request from front to back: byte, last flag, block command and offset.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       new_blk;  // compute a block before use
        logic       restart;  // load counter from the start register first
        logic [5:0] offset;
    } t_req;

    typedef logic [31:0] t_word;

    function automatic t_word rotl(input t_word v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    // One quarter-round on four words, returned packed as {a,b,c,d}.
    function automatic logic [127:0] qround(input t_word a, input t_word b,
                                            input t_word c, input t_word d);
        t_word ta, tb, tc, td;
        ta = a + b;   td = rotl(d ^ ta, 16);
        tc = c + td;  tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        qround = {ta, tb, tc, td};
    endfunction
endpackage
`default_nettype wire

// ===== design/csx_front.sv =====
// Front end: accepts bytes, tracks message offset, classifies block needs.
// Depends on csx_pkg.
`default_nettype none
module csx_front import csx_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire logic [7:0] i_data_in,
    input  wire logic i_msg_last,
    input  wire logic i_q_full,
    output logic      o_full,
    output logic      o_q_wr,
    output t_req      o_q_req
);
    logic       r_ready;
    logic [5:0] r_off;

    assign o_full = i_q_full;
    assign o_q_wr = i_push && !i_q_full;

    // Classify the request
    always_comb begin
        o_q_req.data    = i_data_in;
        o_q_req.last    = i_msg_last;
        o_q_req.restart = !r_ready;
        o_q_req.new_blk = !r_ready || (r_off == 6'd0);
        o_q_req.offset  = r_ready ? r_off : 6'd0;
    end

    // Offset and message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_off   <= 6'd0;
        end else if (o_q_wr) begin
            if (i_msg_last) begin
                r_ready <= 1'b0;
                r_off   <= 6'd0;
            end else begin
                r_ready <= 1'b1;
                r_off   <= o_q_req.offset + 6'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/csx_queue.sv =====
// Short request queue between front and back end.
// Depends on csx_pkg.
`default_nettype none
module csx_queue import csx_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_req i_req,
    input  wire logic i_rd,
    output logic      o_full,
    output logic      o_empty,
    output t_req      o_req
);
    t_req r_mem [QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_req;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end

    `include "chacha20_stream_xor_unit_defines.svh"
    `CSX_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, o_full, !i_wr)
    `CSX_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, o_empty, !i_rd)
    `CSX_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'(QDEPTH))
endmodule
`default_nettype wire

// ===== design/csx_back.sv =====
// Back end: computes keystream blocks one quarter-round per cycle, XORs bytes.
// Depends on csx_pkg.
`default_nettype none
module csx_back import csx_pkg::*; #(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic [255:0] i_key,
    input  wire logic [95:0]  i_nonce,
    input  wire logic [31:0]  i_start,
    input  wire logic i_q_empty,
    input  wire t_req i_q_req,
    output logic      o_q_rd,
    input  wire logic i_pop,
    output logic      o_empty,
    output logic [7:0] o_data_out,
    output logic      o_out_last
);
    localparam int RW = $clog2(DOUBLE_ROUNDS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INIT = 4'b0010,
        S_RND  = 4'b0100,
        S_ADD  = 4'b1000
    } t_state;

    t_state      r_state;
    t_word       r_w  [16];
    t_word       r_ks [16];
    t_word       r_init [16];
    logic [31:0] r_blk;
    logic [2:0]  r_qr;
    logic [RW-1:0] r_rnd;
    logic        r_ovalid;
    logic [7:0]  r_odata;
    logic        r_olast;
    logic        r_have;     // block for the head request is computed

    logic        out_free;
    logic [3:0]  ia, ib, ic, id;
    logic [127:0] qr;
    t_word       ksw;
    logic [7:0]  ksb;

    assign out_free  = !r_ovalid || i_pop;
    assign o_q_rd    = (r_state == S_IDLE) && !i_q_empty && out_free
                       && (!i_q_req.new_blk || r_have);
    assign o_empty   = !r_ovalid;
    assign o_data_out = r_odata;
    assign o_out_last = r_olast;

    // Quarter-round index selection: columns, then diagonals
    always_comb begin
        ia = {2'b00, r_qr[1:0]};
        ib = {2'b01, r_qr[1:0] + (r_qr[2] ? 2'd1 : 2'd0)};
        ic = {2'b10, r_qr[1:0] + (r_qr[2] ? 2'd2 : 2'd0)};
        id = {2'b11, r_qr[1:0] + (r_qr[2] ? 2'd3 : 2'd0)};
        qr = qround(r_w[ia], r_w[ib], r_w[ic], r_w[id]);
    end

    assign ksw = r_ks[i_q_req.offset[5:2]];
    assign ksb = 8'(ksw >> {i_q_req.offset[1:0], 3'b000});

    // Block sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_blk   <= 32'd0;
            r_qr    <= 3'd0;
            r_rnd   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty && i_q_req.new_blk && !r_have) begin
                        if (i_q_req.restart) r_blk <= i_start;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_qr    <= 3'd0;
                    r_rnd   <= '0;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_qr <= r_qr + 3'd1;
                    if (r_qr == 3'd7) begin
                        r_rnd <= r_rnd + RW'(1);
                        if (r_rnd == RW'(DOUBLE_ROUNDS - 1)) r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_blk   <= r_blk + 32'd1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Working state and keystream registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT) begin
            r_init[0] <= SIGMA0; r_init[1] <= SIGMA1;
            r_init[2] <= SIGMA2; r_init[3] <= SIGMA3;
            r_w[0] <= SIGMA0; r_w[1] <= SIGMA1;
            r_w[2] <= SIGMA2; r_w[3] <= SIGMA3;
            for (int k = 0; k < 8; k++) begin
                r_init[4+k] <= i_key[32*k +: 32];
                r_w[4+k]    <= i_key[32*k +: 32];
            end
            r_init[12] <= r_blk; r_w[12] <= r_blk;
            for (int k = 0; k < 3; k++) begin
                r_init[13+k] <= i_nonce[32*k +: 32];
                r_w[13+k]    <= i_nonce[32*k +: 32];
            end
        end else if (r_state == S_RND) begin
            r_w[ia] <= qr[127:96];
            r_w[ib] <= qr[95:64];
            r_w[ic] <= qr[63:32];
            r_w[id] <= qr[31:0];
        end
        if (r_state == S_ADD) begin
            for (int k = 0; k < 16; k++) r_ks[k] <= r_w[k] + r_init[k];
        end
    end

    // Output register; block flag set when a block lands, cleared when the head is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            if (r_state == S_ADD) r_have <= 1'b1;
            if (o_q_rd) r_have <= 1'b0;
            if (o_q_rd) r_ovalid <= 1'b1;
            else if (i_pop) r_ovalid <= 1'b0;
        end
        if (o_q_rd) begin
            r_odata <= i_q_req.data ^ ksb;
            r_olast <= i_q_req.last;
        end
    end

    // Sequencer and read-out checks
    `include "chacha20_stream_xor_unit_defines.svh"
    `CSX_ASSERT_NEXT(a_add_to_idle, i_clk, i_rst_n, r_state == S_ADD, r_state == S_IDLE)
    `CSX_ASSERT_IMP(a_rd_idle, i_clk, i_rst_n, o_q_rd, r_state == S_IDLE)
    `CSX_ASSERT_NEXT(a_rd_valid, i_clk, i_rst_n, o_q_rd, r_ovalid)
endmodule
`default_nettype wire

// ===== design/chacha20_stream_xor_unit.sv =====
// A byte that opens a block waits at the queue head while the block is computed in
// S_INIT, S_RND and S_ADD; each byte then moves from queue head to result register.
// The single quarter-round unit sets the block rate; no byte is read while it runs.
// Reset: synchronous active low; clears queue, offsets, counter, config to zero.
// Queue of two requests between front end and back end; output held until popped.
`default_nettype none
module chacha20_stream_xor_unit import csx_pkg::*; #(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_data_in,
    input  wire logic        i_msg_last,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [7:0]       o_data_out,
    output logic             o_out_last,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);
    logic [255:0] r_key;
    logic [95:0]  r_nonce;
    logic [31:0]  r_start;
    logic q_wr, q_rd, q_full, q_empty;
    t_req w_req, q_req;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0; r_nonce <= '0; r_start <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_KEY01:   r_key[63:0]    <= i_cfg_data;
                REG_KEY23:   r_key[127:64]  <= i_cfg_data;
                REG_KEY45:   r_key[191:128] <= i_cfg_data;
                REG_KEY67:   r_key[255:192] <= i_cfg_data;
                REG_NONCE01: r_nonce[63:0]  <= i_cfg_data;
                REG_NONCE2:  r_nonce[95:64] <= i_cfg_data[31:0];
                REG_START:   r_start        <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    csx_front u_front (
        .i_clk, .i_rst_n, .i_push, .i_data_in, .i_msg_last,
        .i_q_full(q_full), .o_full, .o_q_wr(q_wr), .o_q_req(w_req)
    );

    csx_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(q_wr), .i_req(w_req), .i_rd(q_rd),
        .o_full(q_full), .o_empty(q_empty), .o_req(q_req)
    );

    csx_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
        .i_clk, .i_rst_n, .i_key(r_key), .i_nonce(r_nonce), .i_start(r_start),
        .i_q_empty(q_empty), .i_q_req(q_req), .o_q_rd(q_rd),
        .i_pop, .o_empty, .o_data_out, .o_out_last
    );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for chacha20_stream_xor_unit: bytes go through the push/full
// queue, results leave through empty/pop, and every result is checked by a keystream predictor.
// Depends on csx_pkg and the RTL of the unit.
`default_nettype none
module testbench import csx_pkg::*; ();

    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Keystream predictor and store of expected output bytes
    class xor_scoreboard;
        bit [63:0] key_pair[4];
        bit [63:0] nonce_lo;
        bit [31:0] nonce_hi;
        bit [31:0] first_ctr;
        bit [31:0] ks[16];
        bit [31:0] mix[16];
        bit [5:0]  pos;
        bit [31:0] ctr;
        bit        have_block;
        bit [8:0]  expected_q[$];
        int        errors;
        int        checked;

        function void write_reg(bit [2:0] idx, bit [63:0] v);
            case (idx)
                REG_KEY01:   key_pair[0] = v;
                REG_KEY23:   key_pair[1] = v;
                REG_KEY45:   key_pair[2] = v;
                REG_KEY67:   key_pair[3] = v;
                REG_NONCE01: nonce_lo = v;
                REG_NONCE2:  nonce_hi = v[31:0];
                REG_START:   first_ctr = v[31:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] rol(bit [31:0] x, int s);
            return (x << s) | (x >> (32 - s));
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], 16);
            mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], 12);
            mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], 8);
            mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], 7);
        endfunction

        // Build the next 64-byte keystream block and advance the counter
        function void next_block();
            bit [31:0] init[16];
            init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
            for (int i = 0; i < 4; i++) begin
                init[4 + 2 * i] = key_pair[i][31:0];
                init[5 + 2 * i] = key_pair[i][63:32];
            end
            init[12] = ctr;
            init[13] = nonce_lo[31:0];
            init[14] = nonce_lo[63:32];
            init[15] = nonce_hi;
            mix = init;
            for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
                quarter(0, 4, 8, 12);  quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14); quarter(3, 7, 11, 15);
                quarter(0, 5, 10, 15); quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);  quarter(3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++) ks[i] = mix[i] + init[i];
            ctr += 1;
        endfunction

        function void note_request(bit [7:0] d, bit last);
            bit [7:0] kb;
            if (!have_block) begin
                ctr = first_ctr;
                pos = 0;
                next_block();
                have_block = 1;
            end else if (pos == 0) begin
                next_block();
            end
            kb = 8'(ks[pos[5:2]] >> (pos[1:0] * 8));
            expected_q.push_back({d ^ kb, last});
            pos += 1;
            if (last) begin
                have_block = 0;
                pos = 0;
            end
        endfunction

        function void check_result(bit [7:0] d, bit last);
            bit [8:0] exp_r;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: data_out=%h out_last=%b", d, last);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (d !== exp_r[8:1]) begin
                $error("data_out: expected %h, actual %h", exp_r[8:1], d);
                errors++;
            end
            if (last !== exp_r[0]) begin
                $error("out_last: expected %b, actual %b", exp_r[0], last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_push, i_msg_last, i_pop, i_cfg_we;
    logic [7:0]  i_data_in;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        o_full, o_empty, o_out_last;
    logic [7:0]  o_data_out;

    xor_scoreboard sb;
    int tx_gap_pct;
    int rx_stall_pct;
    int sent;
    int messages;

    chacha20_stream_xor_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full),
        .i_data_in(i_data_in), .i_msg_last(i_msg_last),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_data_out(o_data_out), .o_out_last(o_out_last),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Receiver: random stalls on pop
    always @(posedge i_clk) begin
        if (!i_rst_n) i_pop <= 1'b0;
        else i_pop <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Monitor: config mirror, accepted requests and accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_idx, i_cfg_data);
            if (i_push && !o_full) sb.note_request(i_data_in, i_msg_last);
            if (i_pop && !o_empty) sb.check_result(o_data_out, o_out_last);
        end
    end

    task automatic send_byte(input bit [7:0] d, input bit last);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push     <= 1'b1;
        i_data_in  <= d;
        i_msg_last <= last;
        do @(posedge i_clk); while (o_full);
        sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
        messages++;
    endtask

    task automatic drain();
        i_push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // All registers in one burst, plus a write to the unused index
    task automatic write_config(input bit [63:0] k0, input bit [63:0] k1,
                                input bit [63:0] k2, input bit [63:0] k3,
                                input bit [63:0] n01, input bit [63:0] n2,
                                input bit [63:0] st);
        bit [63:0] vals[7];
        vals = '{k0, k1, k2, k3, n01, n2, st};
        i_cfg_we <= 1'b1;
        for (int i = 0; i < 7; i++) begin
            i_cfg_idx  <= t_reg_idx'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_idx  <= REG_UNUSED;
        i_cfg_data <= {$urandom, $urandom};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic bit [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic set_idle(input int mode);
        case (mode % 4)
            0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_gap_pct = 47; rx_stall_pct = 0;  end
            2: begin tx_gap_pct = 0;  rx_stall_pct = 47; end
            default: begin tx_gap_pct = 8; rx_stall_pct = 8; end
        endcase
    endtask

    initial begin
        int len;
        sb = new;
        i_rst_n = 1'b0; i_push = 1'b0; i_data_in = '0; i_msg_last = 1'b0;
        i_pop = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        tx_gap_pct = 0; rx_stall_pct = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, single-byte messages, field extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
        // All-ones key, nonce and start counter; these short messages use only the first block
        write_config('1, '1, '1, '1, '1, '1, '1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        // Random phases over several configurations
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: write_config(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(),
                                rnd64());
                1: write_config('1, '1, '1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
                2: write_config('0, '0, '0, '0, '0, '0, '0);
                default: write_config(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(),
                                      {$urandom, 32'hFFFF_FFFF});
            endcase
            set_idle(ph);
            for (int n = 0; n < 150; n += len) begin
                case ($urandom_range(9))
                    0: len = 64;
                    1: len = 65 + $urandom_range(80);
                    default: len = 1 + $urandom_range(40);
                endcase
                send_message(len);
                if (n == 0) begin
                    // Hold off until the unit is fully drained once per phase
                    drain();
                    set_idle(ph + 2);
                end
            end
            drain();
        end

        $display("covered %0d bytes in %0d messages under 8 configurations and 4 idle mixes",
                 sent, messages);
        $display("%0d results checked", sb.checked);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
